// ----- sv/flcd_pkg.sv -----
// Package: shared constants, types and helpers for the fixed-length code decoder.
`timescale 1ns / 1ps
package flcd_pkg;

   localparam int MAX_CODE_BITS = 8;
   localparam int COUNT_BITS    = 16;
   localparam int TABLE_DEPTH   = 1 << MAX_CODE_BITS;
   localparam int WIDTH_BITS    = 4;
   localparam int FREQ_BITS     = 16;
   localparam int WIDE_BITS     = (COUNT_BITS > FREQ_BITS) ? COUNT_BITS : FREQ_BITS;

   typedef logic [MAX_CODE_BITS-1:0] code_type;
   typedef logic [COUNT_BITS-1:0]    count_type;
   typedef logic [WIDTH_BITS-1:0]    width_type;
   typedef logic [FREQ_BITS-1:0]     freq_type;
   typedef logic [7:0]               symbol_type;

   localparam width_type CODE_WIDTH_RESET = width_type'(8);
   localparam count_type COUNT_MAX        = '1;

   typedef enum logic {
      FUNC_LOAD = 1'b0,
      FUNC_BIT  = 1'b1
   } func_type;

   // One table write from the second stage.
   typedef struct packed {
      logic       en;
      logic       is_load;
      code_type   idx;
      symbol_type symbol;
      count_type  count;
   } tbl_wr_type;

   // Registered lookup data.
   typedef struct packed {
      symbol_type symbol;
      logic       valid;
      count_type  count;
   } tbl_rd_type;

   function automatic width_type eff_width(input width_type w);
      width_type r;
      r = w;
      if (w == '0) begin
         r = width_type'(1);
      end else if (w > width_type'(MAX_CODE_BITS)) begin
         r = width_type'(MAX_CODE_BITS);
      end
      return r;
   endfunction

   function automatic code_type width_mask(input width_type w);
      code_type ones;
      ones = '1;
      return ones >> (width_type'(MAX_CODE_BITS) - w);
   endfunction

   function automatic freq_type sat_freq(input count_type c);
      logic [WIDE_BITS-1:0] cw;
      logic [WIDE_BITS-1:0] fmax;
      cw   = WIDE_BITS'(c);
      fmax = WIDE_BITS'({FREQ_BITS{1'b1}});
      return (cw > fmax) ? '1 : cw[FREQ_BITS-1:0];
   endfunction

endpackage

// ----- sv/flcd_table.sv -----
// Code table: symbol memory, count memory and entry valid bits with write bypass.
`timescale 1ns / 1ps
module flcd_table
   import flcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       rd_en,
   input  code_type   rd_idx,
   input  tbl_wr_type wr,
   output tbl_rd_type rd
);

   symbol_type                 sym_mem [TABLE_DEPTH];
   count_type                  cnt_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]     valid_ff;
   logic [TABLE_DEPTH-1:0]     valid_in;
   tbl_rd_type                 rd_ff;
   logic                       hit;

   assign hit = wr.en && (wr.idx == rd_idx);

   always_comb begin
      valid_in = valid_ff;
      if (wr.en && wr.is_load) begin
         valid_in[wr.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr.is_load) begin
         sym_mem[wr.idx] <= wr.symbol;
      end
      if (wr.en) begin
         cnt_mem[wr.idx] <= wr.count;
      end
   end

   // Read registered at accept; a write landing at the same edge wins.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff.symbol <= (hit && wr.is_load) ? wr.symbol : sym_mem[rd_idx];
         rd_ff.count  <= hit ? wr.count : cnt_mem[rd_idx];
         rd_ff.valid  <= (hit && wr.is_load) ? 1'b1 : valid_ff[rd_idx];
      end
   end

   assign rd = rd_ff;

endmodule

// ----- sv/fixed_length_code_decoder.sv -----
// Top level: fixed-length code decoder with code table and result register.
`timescale 1ns / 1ps
// Usage
//   req_* channel: one beat per table load (req_func = 0: req_entry_code,
//   req_entry_symbol) or per message bit (req_func = 1: req_message_bit,
//   req_message_end). Beat taken when req_valid is high and req_stall low.
//   rsp_* channel: one beat per completed code word or per short chunk closed
//   by req_message_end; taken when rsp_valid is high and rsp_stall low.
//   csr_* channel: writes code_width; csr_ready is always high. Write only
//   while the block is idle.
// Timing: a taken input beat is registered into stage 1; its result moves into
//   the output register when stage 1 retires.
// Throughput: one input beat per cycle while req_stall is low; every beat does
//   one table read at accept and at most one table write when it retires from
//   the second stage (single write port, same-index bypass between the two).
// Reset: clears the entry valid bits, the chunk, the bit count, the pipeline
//   and code_width (back to 8). No clearing pass; tables are ready at once.
// Stall: with a result held under rsp_stall, beats still enter stage 1 until one
//   that makes a result is there; req_stall then rises until the output frees up.
module fixed_length_code_decoder
   import flcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // input beats
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_func,
   input  logic [7:0] req_entry_code,
   input  logic [7:0] req_entry_symbol,
   input  logic       req_message_bit,
   input  logic       req_message_end,
   // result beats
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_symbol,
   output logic       rsp_known,
   output logic [15:0] rsp_frequency,
   output logic       rsp_last,
   // config write
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_code_width
);

   // config
   width_type  code_width_ff;
   width_type  w_eff;
   code_type   mask;

   // chunk state
   code_type   chunk_ff, chunk_in;
   width_type  gathered_ff, gathered_in;

   // stage 0 decode
   logic       accept;
   logic       is_load;
   code_type   shifted;
   width_type  gathered_inc;
   logic       complete;
   logic       has_result;
   code_type   rd_idx;

   // stage 1
   logic       s1_valid_ff;
   logic       s1_load_ff;
   logic       s1_lookup_ff;
   logic       s1_result_ff;
   logic       s1_last_ff;
   code_type   s1_idx_ff;
   symbol_type s1_symbol_ff;
   logic       s1_go;
   logic       hit;
   count_type  cnt_next;

   tbl_wr_type wr;
   tbl_rd_type rd;

   // output register
   logic       rsp_valid_ff;
   symbol_type rsp_symbol_ff;
   logic       rsp_known_ff;
   freq_type   rsp_freq_ff;
   logic       rsp_last_ff;

   assign csr_ready = 1'b1;
   assign w_eff     = eff_width(code_width_ff);
   assign mask      = width_mask(w_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         code_width_ff <= CODE_WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         code_width_ff <= csr_code_width;
      end
   end

   // Stage 1 can retire when it makes no result or the output slot frees up.
   assign s1_go     = !s1_valid_ff || !s1_result_ff || !rsp_valid_ff || !rsp_stall;
   assign req_stall = !s1_go;
   assign accept    = req_valid && s1_go;

   // ---------------- stage 0: chunk gathering and table read ----------------
   assign is_load      = (req_func == FUNC_LOAD);
   assign shifted      = {chunk_ff[MAX_CODE_BITS-2:0], req_message_bit};
   assign gathered_inc = (gathered_ff == '1) ? gathered_ff : gathered_ff + width_type'(1);
   assign complete     = !is_load && (gathered_inc >= w_eff);
   assign has_result   = !is_load && (complete || req_message_end);
   assign rd_idx       = is_load ? (code_type'(req_entry_code) & mask) : (shifted & mask);

   always_comb begin
      chunk_in    = chunk_ff;
      gathered_in = gathered_ff;
      if (accept && !is_load) begin
         if (has_result) begin
            chunk_in    = '0;
            gathered_in = '0;
         end else begin
            chunk_in    = shifted;
            gathered_in = gathered_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff    <= '0;
         gathered_ff <= '0;
      end else begin
         chunk_ff    <= chunk_in;
         gathered_ff <= gathered_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_go) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_load_ff   <= is_load;
         s1_lookup_ff <= complete;
         s1_result_ff <= has_result;
         s1_last_ff   <= req_message_end;
         s1_idx_ff    <= rd_idx;
         s1_symbol_ff <= req_entry_symbol;
      end
   end

   // ---------------- stage 1: count update and result ----------------
   assign hit      = s1_lookup_ff && rd.valid;
   assign cnt_next = (rd.count == COUNT_MAX) ? rd.count : rd.count + count_type'(1);

   always_comb begin
      wr.en      = s1_valid_ff && s1_go && (s1_load_ff || hit);
      wr.is_load = s1_load_ff;
      wr.idx     = s1_idx_ff;
      wr.symbol  = s1_symbol_ff;
      wr.count   = s1_load_ff ? '0 : cnt_next;
   end

   flcd_table u_table (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (accept),
      .rd_idx (rd_idx),
      .wr     (wr),
      .rd     (rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_valid_ff && s1_result_ff && s1_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_result_ff && s1_go) begin
         rsp_symbol_ff <= hit ? rd.symbol : '0;
         rsp_known_ff  <= hit;
         rsp_freq_ff   <= hit ? sat_freq(cnt_next) : '0;
         rsp_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_symbol    = rsp_symbol_ff;
   assign rsp_known     = rsp_known_ff;
   assign rsp_frequency = rsp_freq_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ----- sv/flcd_checker.sv -----
// Checker: port-level assertions for the decoder, bound to the top level.
`timescale 1ns / 1ps
module flcd_checker
   import flcd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_symbol,
   input logic       rsp_known,
   input logic [15:0] rsp_frequency,
   input logic       rsp_last
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_symbol)
         && $stable(rsp_known) && $stable(rsp_frequency) && $stable(rsp_last))
      else $error("stalled result beat changed");

   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_known |-> rsp_symbol == 8'd0 && rsp_frequency == 16'd0)
      else $error("unknown code carries data");

   a_known_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_known |-> rsp_frequency != 16'd0)
      else $error("known code with zero count");

endmodule

bind fixed_length_code_decoder flcd_checker u_flcd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_symbol    (rsp_symbol),
   .rsp_known     (rsp_known),
   .rsp_frequency (rsp_frequency),
   .rsp_last      (rsp_last)
);
